/* rtl/mar_pkg.sv */
// Package for the matrix axis reduction core: codes, defaults and shared types.
package mar_pkg;

  // Default sizes of the core.
  localparam int unsigned MaxColumnsDefault = 1024;
  localparam int unsigned MaxRowsDefault    = 4096;
  localparam int unsigned DataWidthDefault  = 32;

  // Fixed widths of the configuration port and of the result index.
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned OpW       = 2;
  localparam int unsigned AxisW     = 2;
  localparam int unsigned RowFieldW = 13;
  localparam int unsigned ColFieldW = 11;
  localparam int unsigned IndexW    = 12;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    RegOperation   = 3'd0,
    RegReduceAxis  = 3'd1,
    RegRowCount    = 3'd2,
    RegColumnCount = 3'd3
  } reg_index_e;

  // Reduction kinds; the unused code behaves as a sum.
  typedef enum logic [OpW-1:0] {
    OpMax = 2'd0,
    OpMin = 2'd1,
    OpSum = 2'd2
  } op_e;

  // Reduction axes; the unused code behaves as a whole-matrix reduction.
  typedef enum logic [AxisW-1:0] {
    AxisColumn = 2'd0,
    AxisRow    = 2'd1,
    AxisMatrix = 2'd2
  } axis_e;

  localparam logic [OpW-1:0]   OpReset   = OpMax;
  localparam logic [AxisW-1:0] AxisReset = AxisMatrix;

  // Control of one element in the combine stage.
  typedef struct packed {
    logic init;        // element starts a new accumulation
    logic has_result;  // element completes a row, a column or the matrix
    logic is_last;     // that result is the final one of the matrix
    logic col_axis;    // accumulation lives in the column store
  } stage_ctrl_t;

endpackage

/* rtl/matrix_axis_reduce_core.sv */
// Matrix reduction core: maximum, minimum or sum per column, per row or whole matrix.
// A result is registered as the element that completes it leaves the combine stage.
// Throughput: one element per cycle; the column store is read at transfer and written back
// as the element leaves the combine stage, with a forwarding register covering a read of the
// entry in flight. An element with a result waits only while an untaken result is held.
// Reset clears the control state, the positions and the running accumulator and loads the
// register defaults; the column store is not cleared, the first row of each matrix fills it.
module matrix_axis_reduce_core #(
  parameter int unsigned MAX_COLUMNS = mar_pkg::MaxColumnsDefault,
  parameter int unsigned MAX_ROWS    = mar_pkg::MaxRowsDefault,
  parameter int unsigned DATA_WIDTH  = mar_pkg::DataWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mar_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [mar_pkg::CfgDataW-1:0]  cfg_data_i,
  // Element stream.
  input  logic                          element_valid_i,
  output logic                          element_ready_o,
  input  logic signed [DATA_WIDTH-1:0]  element_value_i,
  // Result stream.
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic signed [DATA_WIDTH-1:0]  reduced_value_o,
  output logic [mar_pkg::IndexW-1:0]    result_index_o,
  output logic                          last_result_o
);

  localparam int unsigned ColAddrW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RowPosW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColCntW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RowCntW  = $clog2(MAX_ROWS + 1);

  // Combine an accumulator with an element.
  function automatic logic [DATA_WIDTH-1:0] combine(
    input logic [mar_pkg::OpW-1:0] op,
    input logic [DATA_WIDTH-1:0]   a,
    input logic [DATA_WIDTH-1:0]   b
  );
    logic [DATA_WIDTH-1:0] res;
    unique case (op)
      mar_pkg::OpMax: res = ($signed(b) > $signed(a)) ? b : a;
      mar_pkg::OpMin: res = ($signed(b) < $signed(a)) ? b : a;
      default:        res = a + b;
    endcase
    return res;
  endfunction

  // Configuration registers.
  logic [mar_pkg::OpW-1:0]   op_q;
  logic [mar_pkg::AxisW-1:0] axis_q;
  logic [RowCntW-1:0]        row_cnt_q;
  logic [ColCntW-1:0]        col_cnt_q;
  logic                      cfg_hit;
  logic [RowCntW-1:0]        row_cnt_new;
  logic [ColCntW-1:0]        col_cnt_new;
  logic [31:0]               row_field;
  logic [31:0]               col_field;

  assign cfg_ready_o = 1'b1;

  // Count writes: zero becomes one, values above the maximum saturate.
  assign row_field = 32'(cfg_data_i[mar_pkg::RowFieldW-1:0]);
  assign col_field = 32'(cfg_data_i[mar_pkg::ColFieldW-1:0]);

  always_comb begin
    if (row_field == 32'd0) begin
      row_cnt_new = RowCntW'(1);
    end else if (row_field > 32'(MAX_ROWS)) begin
      row_cnt_new = RowCntW'(MAX_ROWS);
    end else begin
      row_cnt_new = RowCntW'(row_field);
    end
    if (col_field == 32'd0) begin
      col_cnt_new = ColCntW'(1);
    end else if (col_field > 32'(MAX_COLUMNS)) begin
      col_cnt_new = ColCntW'(MAX_COLUMNS);
    end else begin
      col_cnt_new = ColCntW'(col_field);
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mar_pkg::RegOperation,
        mar_pkg::RegReduceAxis,
        mar_pkg::RegRowCount,
        mar_pkg::RegColumnCount: cfg_hit = 1'b1;
        default:                 cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= mar_pkg::OpReset;
      axis_q    <= mar_pkg::AxisReset;
      row_cnt_q <= RowCntW'(1);
      col_cnt_q <= ColCntW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mar_pkg::RegOperation:   op_q      <= cfg_data_i[mar_pkg::OpW-1:0];
        mar_pkg::RegReduceAxis:  axis_q    <= cfg_data_i[mar_pkg::AxisW-1:0];
        mar_pkg::RegRowCount:    row_cnt_q <= row_cnt_new;
        mar_pkg::RegColumnCount: col_cnt_q <= col_cnt_new;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic                 s1_valid_q;
  mar_pkg::stage_ctrl_t s1_ctrl_q;
  logic                 s1_adv;
  logic                 out_free;
  logic                 in_xfer;

  assign out_free        = !result_valid_o || result_ready_i;
  assign s1_adv          = s1_valid_q && (!s1_ctrl_q.has_result || out_free);
  assign element_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer         = element_valid_i && element_ready_o;

  // Matrix positions and the flags of the element being transferred.
  logic [RowPosW-1:0]   row_pos_q;
  logic [ColAddrW-1:0]  col_pos_q;
  logic                 first_row;
  logic                 first_col;
  logic                 last_row;
  logic                 last_col;
  mar_pkg::stage_ctrl_t in_ctrl;
  logic [mar_pkg::IndexW-1:0] in_index;

  assign first_row = (row_pos_q == '0);
  assign first_col = (col_pos_q == '0);
  assign last_row  = (RowCntW'(row_pos_q) + RowCntW'(1)) >= row_cnt_q;
  assign last_col  = (ColCntW'(col_pos_q) + ColCntW'(1)) >= col_cnt_q;

  always_comb begin
    in_ctrl.col_axis = 1'b0;
    unique case (axis_q)
      mar_pkg::AxisColumn: begin
        in_ctrl.col_axis   = 1'b1;
        in_ctrl.init       = first_row;
        in_ctrl.has_result = last_row;
        in_ctrl.is_last    = last_col;
        in_index           = mar_pkg::IndexW'(col_pos_q);
      end
      mar_pkg::AxisRow: begin
        in_ctrl.init       = first_col;
        in_ctrl.has_result = last_col;
        in_ctrl.is_last    = last_row;
        in_index           = mar_pkg::IndexW'(row_pos_q);
      end
      default: begin
        in_ctrl.init       = first_row && first_col;
        in_ctrl.has_result = last_row && last_col;
        in_ctrl.is_last    = 1'b1;
        in_index           = '0;
      end
    endcase
  end

  // Positions advance on each element transfer; a register write starts a new matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else if (cfg_hit) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else if (in_xfer) begin
      if (last_col) begin
        col_pos_q <= '0;
        row_pos_q <= last_row ? '0 : row_pos_q + RowPosW'(1);
      end else begin
        col_pos_q <= col_pos_q + ColAddrW'(1);
      end
    end
  end

  // Column store: read at transfer, written back as the element leaves the combine stage.
  logic                  ram_we;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [ColAddrW-1:0]   s1_col_q;
  logic [DATA_WIDTH-1:0] s1_value_q;
  logic [DATA_WIDTH-1:0] acc;

  assign ram_we = s1_adv && s1_ctrl_q.col_axis;

  mar_ram #(
    .Width (DATA_WIDTH),
    .Depth (MAX_COLUMNS)
  ) u_col_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_col_q),
    .wdata_i (acc),
    .re_i    (in_xfer),
    .raddr_i (col_pos_q),
    .rdata_o (ram_rdata)
  );

  // Forwarding: a read that meets the write-back of the same entry takes the new value.
  logic                  fwd_q;
  logic [DATA_WIDTH-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_xfer) begin
      fwd_q <= ram_we && (s1_col_q == col_pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fwd_data_q <= acc;
    end
  end

  // Combine stage registers.
  logic [mar_pkg::IndexW-1:0] s1_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
    end else if (element_ready_o) begin
      s1_valid_q <= element_valid_i;
      s1_ctrl_q  <= in_ctrl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_value_q <= element_value_i;
      s1_col_q   <= col_pos_q;
      s1_index_q <= in_index;
    end
  end

  // One combine against either the column entry or the running accumulator.
  logic [DATA_WIDTH-1:0] running_q;
  logic [DATA_WIDTH-1:0] col_entry;
  logic [DATA_WIDTH-1:0] acc_base;

  assign col_entry = fwd_q ? fwd_data_q : ram_rdata;
  assign acc_base  = s1_ctrl_q.col_axis ? col_entry : running_q;
  assign acc       = s1_ctrl_q.init ? s1_value_q : combine(op_q, acc_base, s1_value_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else if (cfg_hit) begin
      running_q <= '0;
    end else if (s1_adv && !s1_ctrl_q.col_axis) begin
      running_q <= acc;
    end
  end

  // Output register holds a result until its transfer.
  logic out_load;

  assign out_load = s1_adv && s1_ctrl_q.has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else if (out_load) begin
      result_valid_o <= 1'b1;
    end else if (result_ready_i) begin
      result_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      reduced_value_o <= acc;
      result_index_o  <= s1_index_q;
      last_result_o   <= s1_ctrl_q.is_last;
    end
  end

endmodule

/* rtl/mar_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
module mar_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
